/* rtl/lss_pkg.sv */
// Types and codes shared by the LIFO stack with search.
package lss_pkg;

	localparam int PosWidth = 5;

	localparam logic [1:0] MODE_PUSH    = 2'd0;
	localparam logic [1:0] MODE_POP     = 2'd1;
	localparam logic [1:0] MODE_SEARCH  = 2'd2;
	localparam logic [1:0] MODE_DISPLAY = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]          status;
		logic signed [31:0]  data_out;
		logic [PosWidth-1:0] position;
		logic                last;
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_WALK
	} state_t;

endpackage

/* rtl/lifo_stack_with_search.sv */
// LIFO stack of signed 32-bit values with pop, search and display walk.
//
// Command channel (cmd_valid / cmd_stall / cmd) carries mode and value; the
// result channel (res_valid / res_stall / res) returns status, data_out,
// position and a last flag on the final result of each command.
// Steps from command acceptance until its last result can be taken:
//   push, empty or full  result is registered on acceptance
//   pop                  one registered memory read, then the result
//   search               walks entries from the top until a hit or the
//                        bottom (at most the fill count), then the result
//   display              one result per entry, top to bottom
// A new command is taken after the last result loads, so back to back pushes
// run at one per cycle while res_stall is low. The walk uses one memory read
// port and one 32-bit comparator, one entry per cycle, top to bottom. One
// command is in work at a time: cmd_stall is high from acceptance until the
// command has loaded its last result, and also whenever the output register
// is full and stalled. A result waiting under res_stall holds its value;
// display and a search hit wait with it. Reset empties the stack (fill count
// zero) and drops any pending result; stored entries are not cleared.
module lifo_stack_with_search #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  lss_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output lss_pkg::res_t res
);
	import lss_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	state_t              state_q, state_d;
	logic [1:0]          mode_q;
	logic signed [31:0]  value_q;
	logic [CW-1:0]       count_q, count_d, count_m1;
	logic [AW-1:0]       ptr_q, ptr_d, rd_addr, top_addr;
	logic [PosWidth-1:0] pos_q, pos_d;
	logic signed [31:0]  rd_q;
	logic signed [31:0]  mem [DEPTH];
	logic                mem_we;
	logic                res_valid_q, res_load;
	res_t                res_q, res_d;
	logic                out_free, idle, cmd_acc;
	logic                is_empty, is_full, at_bottom, hit;

	assign out_free  = !res_valid_q || !res_stall;
	assign idle      = (state_q == S_IDLE);
	assign cmd_stall = !(idle && out_free);
	assign cmd_acc   = cmd_valid && idle && out_free;

	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == FULL_CNT);
	assign count_m1  = count_q - 1'b1;
	assign top_addr  = count_m1[AW-1:0];
	assign at_bottom = (ptr_q == '0);
	assign hit       = (rd_q == value_q);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					unique case (cmd.mode)
						MODE_PUSH:    state_d = S_IDLE;
						MODE_POP:     state_d = is_empty ? S_IDLE : S_POP;
						MODE_SEARCH,
						MODE_DISPLAY: state_d = is_empty ? S_IDLE : S_WALK;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_POP: begin
				if (out_free)
					state_d = S_IDLE;
			end
			S_WALK: begin
				if (mode_q == MODE_SEARCH) begin
					if ((hit || at_bottom) && out_free)
						state_d = S_IDLE;
				end else if (at_bottom && out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath control and result build
	always_comb begin
		res_load = 1'b0;
		res_d    = '0;
		mem_we   = 1'b0;
		count_d  = count_q;
		ptr_d    = ptr_q;
		pos_d    = pos_q;
		rd_addr  = ptr_q;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = top_addr;
				ptr_d   = top_addr;
				pos_d   = PosWidth'(1);
				if (cmd_acc) begin
					res_d.last = 1'b1;
					unique case (cmd.mode)
						MODE_PUSH: begin
							res_load = 1'b1;
							if (is_full) begin
								res_d.status = ST_FULL;
							end else begin
								res_d.status = ST_OK;
								mem_we       = 1'b1;
								count_d      = count_q + 1'b1;
							end
						end
						MODE_POP: begin
							if (is_empty) begin
								res_load     = 1'b1;
								res_d.status = ST_EMPTY;
							end else begin
								count_d = count_m1;
							end
						end
						MODE_SEARCH,
						MODE_DISPLAY: begin
							if (is_empty) begin
								res_load     = 1'b1;
								res_d.status = ST_EMPTY;
							end
						end
						default: ;
					endcase
				end
			end
			S_POP: begin
				if (out_free) begin
					res_load       = 1'b1;
					res_d.status   = ST_OK;
					res_d.data_out = rd_q;
					res_d.last     = 1'b1;
				end
			end
			S_WALK: begin
				if (mode_q == MODE_SEARCH) begin
					if (hit) begin
						if (out_free) begin
							res_load       = 1'b1;
							res_d.status   = ST_OK;
							res_d.position = pos_q;
							res_d.last     = 1'b1;
						end
					end else if (at_bottom) begin
						if (out_free) begin
							res_load     = 1'b1;
							res_d.status = ST_NOT_FOUND;
							res_d.last   = 1'b1;
						end
					end else begin
						ptr_d   = ptr_q - 1'b1;
						pos_d   = pos_q + 1'b1;
						rd_addr = ptr_q - 1'b1;
					end
				end else if (out_free) begin
					res_load       = 1'b1;
					res_d.status   = ST_OK;
					res_d.data_out = rd_q;
					res_d.last     = at_bottom;
					if (!at_bottom) begin
						ptr_d   = ptr_q - 1'b1;
						pos_d   = pos_q + 1'b1;
						rd_addr = ptr_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		pos_q <= pos_d;
		if (cmd_acc) begin
			mode_q  <= cmd.mode;
			value_q <= cmd.value;
		end
		if (res_load)
			res_q <= res_d;
	end

	// entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[count_q[AW-1:0]] <= cmd.value;
		rd_q <= mem[rd_addr];
	end

endmodule

/* verif/tb.sv */
// Self-checking testbench for the LIFO stack with push, pop, search and display.
module tb;
	import lss_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 325;
	localparam int QUIET_ITEMS = 60;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		cmd_t c;
		bit   typed;
		res_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	logic signed [31:0] stack_mirror [DEPTH];
	int stack_fill = 0;
	res_t pending_res [$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	bit calm = 1'b0;
	int stall_run = 0;
	int free_run = 0;
	int n_mode [4] = '{default: 0};
	int n_checked = 0;
	int n_full = 0;
	int n_empty = 0;
	int n_hit = 0;
	int n_miss = 0;

	lifo_stack_with_search #(.DEPTH(DEPTH)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver backpressure: stall bursts separated by free stretches, some long
	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			res_stall <= 1'b0;
		end else if (stall_run > 0) begin
			res_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else if (free_run > 0) begin
			res_stall <= 1'b0;
			free_run <= free_run - 1;
		end else begin
			res_stall <= 1'b0;
			stall_run <= $urandom_range(1, 19);
			free_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
			                                        : $urandom_range(0, 12);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %0d data %0h pos %0d last %0b",
				         $time, res.status, res.data_out, res.position, res.last);
				errors++;
			end else begin
				want = pending_res.pop_front();
				n_checked++;
				check_field("status", 32'(want.status), 32'(res.status));
				check_field("data_out", want.data_out, res.data_out);
				check_field("position", 32'(want.position), 32'(res.position));
				check_field("last", 32'(want.last), 32'(res.last));
			end
		end
	end

	// Tracks the stack contents and queues every result one command transaction causes.
	task automatic stack_predict(input cmd_t c, input bit typed, input res_t want);
		res_t r;
		res_t outs [$];
		bit hit;
		r = '0;
		r.status = ST_OK;
		r.last = 1'b1;
		hit = 1'b0;
		n_mode[c.mode]++;
		case (c.mode)
			MODE_PUSH: begin
				if (stack_fill >= DEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					stack_mirror[stack_fill] = c.value;
					stack_fill++;
				end
			end
			MODE_POP: begin
				if (stack_fill == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					stack_fill--;
					r.data_out = stack_mirror[stack_fill];
				end
			end
			MODE_SEARCH: begin
				if (stack_fill == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					r.status = ST_NOT_FOUND;
					// nearest the top wins
					for (int k = 0; k < stack_fill && !hit; k++) begin
						if (stack_mirror[stack_fill - 1 - k] == c.value) begin
							hit = 1'b1;
							r.status = ST_OK;
							r.position = PosWidth'(k + 1);
						end
					end
					if (hit) n_hit++;
					else n_miss++;
				end
			end
			MODE_DISPLAY: begin
				if (stack_fill == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					for (int k = 0; k < stack_fill; k++) begin
						r.data_out = stack_mirror[stack_fill - 1 - k];
						r.last = (k == stack_fill - 1);
						outs.push_back(r);
					end
				end
			end
		endcase
		if (outs.size() == 0) outs.push_back(r);
		if (typed) pending_res.push_back(want);
		else foreach (outs[i]) pending_res.push_back(outs[i]);
	endtask

	task automatic send_cmd(input cmd_t c, input bit typed, input res_t want);
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		stack_predict(c, typed, want);
	endtask

	task automatic maybe_gap();
		if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic drain_wait();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return VAL_MIN;
		if (sel == 1) return VAL_MAX;
		// small pool so duplicates and search hits are common
		if (sel <= 4) return $urandom_range(0, 7) - 4;
		return $urandom;
	endfunction

	function automatic row_t mk_row(input logic [1:0] m, input logic signed [31:0] v,
	                                input bit typed, input res_t want);
		row_t r;
		r.c.mode = m;
		r.c.value = v;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	initial begin
		row_t plan [$];
		cmd_t c;
		res_t none;
		int w;
		bit filling;
		none = '0;
		filling = 1'b0;

		plan.push_back(mk_row(MODE_POP, 0, 1'b1, res_t'{ST_EMPTY, 32'sd0, 5'd0, 1'b1}));
		plan.push_back(mk_row(MODE_SEARCH, 5, 1'b1, res_t'{ST_EMPTY, 32'sd0, 5'd0, 1'b1}));
		plan.push_back(mk_row(MODE_DISPLAY, 0, 1'b1, res_t'{ST_EMPTY, 32'sd0, 5'd0, 1'b1}));
		plan.push_back(mk_row(MODE_PUSH, VAL_MIN, 1'b1, res_t'{ST_OK, 32'sd0, 5'd0, 1'b1}));
		plan.push_back(mk_row(MODE_PUSH, VAL_MAX, 1'b1, res_t'{ST_OK, 32'sd0, 5'd0, 1'b1}));
		plan.push_back(mk_row(MODE_PUSH, -1, 1'b0, none));
		plan.push_back(mk_row(MODE_PUSH, VAL_MAX, 1'b0, none));
		plan.push_back(mk_row(MODE_SEARCH, VAL_MAX, 1'b0, none));
		plan.push_back(mk_row(MODE_SEARCH, 32'sh1234_5678, 1'b1,
		                      res_t'{ST_NOT_FOUND, 32'sd0, 5'd0, 1'b1}));
		plan.push_back(mk_row(MODE_DISPLAY, 0, 1'b0, none));
		plan.push_back(mk_row(MODE_POP, 0, 1'b1, res_t'{ST_OK, VAL_MAX, 5'd0, 1'b1}));
		// three entries left; fill to the top
		for (int k = 0; k < DEPTH - 3; k++)
			plan.push_back(mk_row(MODE_PUSH, (32'sd1 <<< (2 * k)) ^ 32'sh5a5a_0000, 1'b0, none));
		plan.push_back(mk_row(MODE_PUSH, 77, 1'b1, res_t'{ST_FULL, 32'sd0, 5'd0, 1'b1}));
		plan.push_back(mk_row(MODE_DISPLAY, 0, 1'b0, none));
		plan.push_back(mk_row(MODE_SEARCH, VAL_MIN, 1'b0, none));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			maybe_gap();
			send_cmd(plan[i].c, plan[i].typed, plan[i].want);
		end
		drain_wait();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0) begin
				filling = !filling;
				calm = ($urandom_range(0, 3) == 0);
			end
			if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
			if (i == 150) drain_wait();
			w = $urandom_range(0, 99);
			if (filling)
				c.mode = (w < 55) ? MODE_PUSH : (w < 70) ? MODE_POP
				       : (w < 88) ? MODE_SEARCH : MODE_DISPLAY;
			else
				c.mode = (w < 20) ? MODE_PUSH : (w < 65) ? MODE_POP
				       : (w < 85) ? MODE_SEARCH : MODE_DISPLAY;
			if (c.mode == MODE_PUSH)
				c.value = pick_value();
			else if (c.mode == MODE_SEARCH && stack_fill > 0 && $urandom_range(0, 1) == 1)
				c.value = stack_mirror[$urandom_range(0, stack_fill - 1)];
			else if (c.mode == MODE_SEARCH)
				c.value = pick_value();
			else
				c.value = $urandom;
			maybe_gap();
			send_cmd(c, 1'b0, none);
		end

		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_res.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Ran %0d commands (push %0d, pop %0d, search %0d, display %0d), %0d results checked.",
		         n_mode[MODE_PUSH] + n_mode[MODE_POP] + n_mode[MODE_SEARCH] + n_mode[MODE_DISPLAY],
		         n_mode[MODE_PUSH], n_mode[MODE_POP], n_mode[MODE_SEARCH], n_mode[MODE_DISPLAY],
		         n_checked);
		$display("Full rejects %0d, empty-stack cases %0d, search hits %0d, misses %0d.",
		         n_full, n_empty, n_hit, n_miss);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
